// ----- rtl/schroeder_allpass_filter_macros.svh -----
// Assertion macros shared by the allpass filter RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SCHROEDER_ALLPASS_FILTER_MACROS_SVH
`define SCHROEDER_ALLPASS_FILTER_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define APF_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define APF_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/apf_pkg.sv -----
// Shared types and constants for the Schroeder allpass filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package apf_pkg;

    // Parameter defaults
    localparam int MAX_DELAY_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration register fields
    localparam int DELAY_BITS     = 13;
    localparam int GAIN_BITS      = 16;
    localparam int GAIN_FRAC      = 15;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DELAY_LENGTH  = 1'b0,
        REG_FEEDBACK_GAIN = 1'b1
    } apf_reg_e;

    // How the history read data of the sample in flight is to be taken
    typedef struct packed {
        logic fresh;    // entry not yet written since the last clear: reads zero
        logic fwd_hit;  // output entry written on the same edge it was read
    } apf_rd_sel_t;

endpackage

`default_nettype wire

// ----- rtl/schroeder_allpass_filter.sv -----
// Top level of the Schroeder allpass filter: stream ports, ring control, history stores.
// Depends on apf_pkg, apf_hist_mem, apf_calc and schroeder_allpass_filter_macros.svh.
`default_nettype none

`include "schroeder_allpass_filter_macros.svh"

// Schroeder allpass filter, y[n] = x[n-D] - g*x[n] + g*y[n-D], on signed samples.
// One result beat leaves for every sample beat taken, in order. Throughput is one
// sample per clock unless m_tready holds the output back. The sample and both
// history store reads are registered at the compute stage, and the multiply, round
// and saturate result at the output register. The delay D (1..MAX_DELAY, 0 taken
// as 1, larger values clamped) and the Q1.15 gain g are set through the cfg port;
// write them only while no sample is in flight. Writing the delay restarts the
// ring: both stores read as zero until the ring has wrapped once, so no clearing
// sweep is needed and the block stays ready right after reset or a delay write.
// With D = 1 the output store is written on the same edge it is read for the next
// sample; that value is forwarded from a bypass register.
module schroeder_allpass_filter
    import apf_pkg::*;
#(
    parameter int MAX_DELAY   = MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    // Sample input
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata, // [SAMPLE_BITS-1:0] sample_in

    // Filtered output
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata, // [SAMPLE_BITS-1:0] sample_out

    // Register writes
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index, // 0 delay_length, 1 feedback_gain
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int TdataBits = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int AddrBits  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int DlyBits   = ($clog2(MAX_DELAY + 1) > DELAY_BITS) ?
                               $clog2(MAX_DELAY + 1) : DELAY_BITS;

    // Configuration state
    logic [AddrBits-1:0]         last_pos_reg, last_pos_next;
    logic signed [GAIN_BITS-1:0] gain_reg, gain_next;

    // Ring control
    logic [AddrBits-1:0] pos_reg, pos_next;
    logic                filled_reg, filled_next;

    // Compute stage
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_x_reg;
    logic [AddrBits-1:0]           s1_pos_reg;
    apf_rd_sel_t                   s1_sel_reg;
    logic signed [SAMPLE_BITS-1:0] fwd_data_reg;

    // Output register
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_data_reg;

    logic                          s_accept;
    logic                          cfg_accept;
    logic                          out_free;
    logic                          s1_fire;
    logic                          wrap;
    logic signed [SAMPLE_BITS-1:0] x_in;
    logic signed [SAMPLE_BITS-1:0] xd_mem;
    logic signed [SAMPLE_BITS-1:0] yd_mem;
    logic signed [SAMPLE_BITS-1:0] y_calc;
    logic [DlyBits-1:0]            dly_raw;
    logic [DlyBits-1:0]            dly_clamped;

    // ------------------------------------------------------------------
    // Handshakes: the output register frees the compute stage, which in
    // turn frees the input; a waiting result does not block a new beat.
    // ------------------------------------------------------------------
    assign out_free   = !m_valid_reg || m_tready;
    assign s1_fire    = s1_valid_reg && out_free;
    assign s_tready   = !s1_valid_reg || out_free;
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign x_in = s_tdata[SAMPLE_BITS-1:0];
    assign wrap = (pos_reg == last_pos_reg);

    // ------------------------------------------------------------------
    // Configuration decode and ring position
    // ------------------------------------------------------------------
    always_comb begin
        dly_raw = DlyBits'(cfg_data[DELAY_BITS-1:0]);
        priority if (dly_raw == '0) begin
            dly_clamped = DlyBits'(1);
        end else if (dly_raw > DlyBits'(MAX_DELAY)) begin
            dly_clamped = DlyBits'(MAX_DELAY);
        end else begin
            dly_clamped = dly_raw;
        end

        last_pos_next = last_pos_reg;
        gain_next     = gain_reg;
        pos_next      = pos_reg;
        filled_next   = filled_reg;

        // Advance the ring on every accepted sample; mark filled on first wrap.
        if (s_accept) begin
            pos_next = wrap ? '0 : pos_reg + AddrBits'(1);
            if (wrap) begin
                filled_next = 1'b1;
            end
        end

        if (cfg_accept) begin
            unique case (apf_reg_e'(cfg_index))
                REG_DELAY_LENGTH: begin
                    // New length: restart the ring and treat both stores as cleared.
                    last_pos_next = AddrBits'(dly_clamped - DlyBits'(1));
                    pos_next      = '0;
                    filled_next   = 1'b0;
                end
                REG_FEEDBACK_GAIN: begin
                    gain_next = cfg_data[GAIN_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pos_reg <= '0;
            gain_reg     <= '0;
            pos_reg      <= '0;
            filled_reg   <= 1'b0;
        end else begin
            last_pos_reg <= last_pos_next;
            gain_reg     <= gain_next;
            pos_reg      <= pos_next;
            filled_reg   <= filled_next;
        end
    end

    // ------------------------------------------------------------------
    // History stores: read both at the current position on accept; write the
    // input there at once and the output when the compute stage retires.
    // ------------------------------------------------------------------
    apf_hist_mem #(
        .DEPTH     (MAX_DELAY),
        .ADDR_BITS (AddrBits),
        .DATA_BITS (SAMPLE_BITS)
    ) u_in_hist (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (pos_reg),
        .wr_data (x_in),
        .rd_en   (s_accept),
        .rd_addr (pos_reg),
        .rd_data (xd_mem)
    );

    apf_hist_mem #(
        .DEPTH     (MAX_DELAY),
        .ADDR_BITS (AddrBits),
        .DATA_BITS (SAMPLE_BITS)
    ) u_out_hist (
        .aclk    (aclk),
        .wr_en   (s1_fire),
        .wr_addr (s1_pos_reg),
        .wr_data (y_calc),
        .rd_en   (s_accept),
        .rd_addr (pos_reg),
        .rd_data (yd_mem)
    );

    // ------------------------------------------------------------------
    // Compute stage: hold operands while the output register is blocked.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_x_reg           <= x_in;
            s1_pos_reg         <= pos_reg;
            s1_sel_reg.fresh   <= !filled_reg;
            // Same-entry read and write on this edge: the store returns stale data.
            s1_sel_reg.fwd_hit <= s1_fire && (s1_pos_reg == pos_reg);
            fwd_data_reg       <= y_calc;
        end
    end

    apf_calc #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_calc (
        .x      (s1_x_reg),
        .xd_mem (xd_mem),
        .yd_mem (yd_mem),
        .yd_fwd (fwd_data_reg),
        .sel    (s1_sel_reg),
        .gain   (gain_reg),
        .y      (y_calc)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_data_reg <= y_calc;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TdataBits'($unsigned(m_data_reg));

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `APF_ASSERT_ALWAYS(a_pos_in_ring, aclk, aresetn, pos_reg <= last_pos_reg, "ring position beyond delay length")
    `APF_ASSERT_IMPL(a_fwd_only_delay_one, aclk, aresetn, s1_valid_reg && s1_sel_reg.fwd_hit, last_pos_reg == '0 && !s1_sel_reg.fresh, "output forwarding with delay above one")
    `APF_ASSERT_IMPL(a_clear_only_on_cfg, aclk, aresetn, $fell(filled_reg), $past(cfg_accept), "stores marked empty without a delay write")

endmodule

`default_nettype wire

// ----- rtl/apf_hist_mem.sv -----
// One history ring store: single write port, single read port, registered read.
// Uses apf_pkg for its parameter defaults; no submodules.
`default_nettype none

module apf_hist_mem
    import apf_pkg::*;
#(
    parameter int DEPTH      = MAX_DELAY_DEF,
    parameter int ADDR_BITS  = 12,
    parameter int DATA_BITS  = SAMPLE_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];

    // Read-first: a read and a write of the same entry on one edge return the old data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/apf_calc.sv -----
// Allpass arithmetic: y = sat(round((xd*2^15 + g*(yd - x)) / 2^15)).
// Uses apf_pkg for the read-select struct and gain format.
`default_nettype none

module apf_calc
    import apf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic signed [SAMPLE_BITS-1:0] x,
    input  wire logic signed [SAMPLE_BITS-1:0] xd_mem,
    input  wire logic signed [SAMPLE_BITS-1:0] yd_mem,
    input  wire logic signed [SAMPLE_BITS-1:0] yd_fwd,
    input  wire apf_rd_sel_t                   sel,
    input  wire logic signed [GAIN_BITS-1:0]   gain,
    output logic      signed [SAMPLE_BITS-1:0] y
);

    localparam int ProdBits = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int AccBits  = SAMPLE_BITS + GAIN_BITS + 2;
    localparam int QBits    = AccBits - GAIN_FRAC;
    localparam logic signed [QBits-1:0] QMax =
        QBits'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [QBits-1:0] QMin = -QMax - QBits'(1);
    localparam logic signed [AccBits-1:0] RoundHalf = AccBits'(1 << (GAIN_FRAC - 1));

    logic signed [SAMPLE_BITS-1:0] xd;
    logic signed [SAMPLE_BITS-1:0] yd;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [ProdBits-1:0]    prod;
    logic signed [AccBits-1:0]     acc;
    logic signed [QBits-1:0]       q;

    always_comb begin
        // Unwritten entries read zero; same-edge output write is forwarded.
        xd = sel.fresh ? '0 : xd_mem;
        priority if (sel.fresh) begin
            yd = '0;
        end else if (sel.fwd_hit) begin
            yd = yd_fwd;
        end else begin
            yd = yd_mem;
        end

        diff = (SAMPLE_BITS+1)'(yd) - (SAMPLE_BITS+1)'(x);
        prod = ProdBits'(gain) * ProdBits'(diff);
        acc  = (AccBits'(xd) <<< GAIN_FRAC) + AccBits'(prod) + RoundHalf;
        q    = acc[AccBits-1:GAIN_FRAC];

        // Clamp to the sample range
        priority if (q > QMax) begin
            y = QMax[SAMPLE_BITS-1:0];
        end else if (q < QMin) begin
            y = QMin[SAMPLE_BITS-1:0];
        end else begin
            y = q[SAMPLE_BITS-1:0];
        end
    end

endmodule

`default_nettype wire
